// File: rtl/mmn_pkg.sv
// Shared types and constants for the min-max contrast stretch block.
`default_nettype none
package mmn_pkg;

  localparam int PIX_W      = 8;
  localparam int CNT_W      = 7;
  localparam int FULL_SCALE = 255;
  localparam int NUM_W      = 17;
  localparam int REM_W      = 9;
  localparam int DIV_STEPS  = 4;

  typedef struct packed {
    logic              bank;
    logic [PIX_W-1:0]  lo;
    logic [PIX_W-1:0]  range;
    logic [CNT_W-1:0]  cnt;
    logic              ovf;
  } patch_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV0,
    ST_DIV1,
    ST_PUSH
  } back_state_t;

endpackage
`default_nettype wire

// File: rtl/mmn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mmn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/mmn_front.sv
// Front end: accepts samples, stores them and tracks min, max, count and overflow.
`default_nettype none
module mmn_front #(
  parameter int MAX_ELEMENTS = 64,
  parameter int IDX_W        = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [mmn_pkg::PIX_W-1:0]   sample_value,
  input  wire logic                        last_sample,
  input  wire logic                        sample_valid,
  output logic                             sample_ready,
  input  wire mmn_pkg::queue_stat_t        q_stat,
  output logic                             push,
  output mmn_pkg::patch_desc_t             desc,
  output logic                             wr_en,
  output logic [IDX_W:0]                   wr_addr,
  output logic [mmn_pkg::PIX_W-1:0]        wr_data
);
  import mmn_pkg::*;

  logic [PIX_W-1:0] run_min;
  logic [PIX_W-1:0] run_max;
  logic [CNT_W-1:0] cnt;
  logic             ovf;
  logic             bank;

  logic             acc;
  logic             store_ok;
  logic [PIX_W-1:0] min_next;
  logic [PIX_W-1:0] max_next;
  logic [CNT_W-1:0] cnt_next;
  logic             ovf_next;

  always_comb begin
    sample_ready = !q_stat.full;
    acc          = sample_valid && sample_ready;
    store_ok     = cnt < CNT_W'(MAX_ELEMENTS);
    min_next     = (store_ok && sample_value < run_min) ? sample_value : run_min;
    max_next     = (store_ok && sample_value > run_max) ? sample_value : run_max;
    cnt_next     = store_ok ? cnt + CNT_W'(1) : cnt;
    ovf_next     = ovf || !store_ok;

    desc.bank  = bank;
    desc.lo    = min_next;
    desc.range = (max_next >= min_next) ? max_next - min_next : '0;
    desc.cnt   = cnt_next;
    desc.ovf   = ovf_next;
    push       = acc && last_sample;

    wr_en   = acc && store_ok;
    wr_addr = {bank, cnt[IDX_W-1:0]};
    wr_data = sample_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= PIX_W'(FULL_SCALE);
      run_max <= '0;
      cnt     <= '0;
      ovf     <= 1'b0;
      bank    <= 1'b0;
    end else if (acc) begin
      if (last_sample) begin
        run_min <= PIX_W'(FULL_SCALE);
        run_max <= '0;
        cnt     <= '0;
        ovf     <= 1'b0;
        bank    <= !bank;
      end else begin
        run_min <= min_next;
        run_max <= max_next;
        cnt     <= cnt_next;
        ovf     <= ovf_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/mmn_queue.sv
// Two-entry queue of patch descriptors between front and back.
`default_nettype none
module mmn_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire mmn_pkg::patch_desc_t  push_desc,
  input  wire logic                  pop,
  output mmn_pkg::patch_desc_t       head,
  output mmn_pkg::queue_stat_t       stat
);
  import mmn_pkg::*;

  patch_desc_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  always_comb begin
    head       = entries[rd_ptr];
    stat.full  = count == 2'd2;
    stat.empty = count == 2'd0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/mmn_back.sv
// Back end: reads stored samples, scales each by restoring division, drives results.
`default_nettype none
module mmn_back #(
  parameter int IDX_W = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mmn_pkg::queue_stat_t        q_stat,
  input  wire mmn_pkg::patch_desc_t        head,
  output logic                             pop,
  output logic [IDX_W:0]                   rd_addr,
  input  wire logic [mmn_pkg::PIX_W-1:0]   rd_data,
  output logic [mmn_pkg::PIX_W-1:0]        scaled_value,
  output logic                             last_result,
  output logic                             overflow,
  output logic                             result_valid,
  input  wire logic                        result_ready
);
  import mmn_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  logic [CNT_W-1:0] k;
  logic [REM_W-1:0] rem;
  logic [PIX_W-1:0] num_lo;
  logic [PIX_W-1:0] quo;

  logic             is_last;
  logic             out_free;
  logic             load_out;
  logic [PIX_W-1:0] samp;
  logic [PIX_W-1:0] diff;
  logic [NUM_W-1:0] numer;
  logic [REM_W-1:0] dvs;
  logic [REM_W-1:0] rem_step;
  logic [PIX_W-1:0] num_step;
  logic [PIX_W-1:0] quo_step;
  logic [REM_W:0]   trial;

  always_comb begin
    is_last  = (k + CNT_W'(1)) == head.cnt;
    out_free = !result_valid || result_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!q_stat.empty) state_next = ST_READ;
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV0;
      ST_DIV0: state_next = ST_DIV1;
      ST_DIV1: state_next = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          state_next = is_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    load_out = (state == ST_PUSH) && out_free;
    pop      = load_out && is_last;
    rd_addr  = {head.bank, k[IDX_W-1:0]};
  end

  // dividend = 2*(v-lo)*255 + range, divisor = 2*range
  always_comb begin
    samp  = (rd_data < head.lo) ? head.lo : rd_data;
    diff  = samp - head.lo;
    numer = NUM_W'(diff) * NUM_W'(2 * FULL_SCALE) + NUM_W'(head.range);
    dvs   = {head.range, 1'b0};
  end

  always_comb begin
    rem_step = rem;
    num_step = num_lo;
    quo_step = quo;
    trial    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial    = {rem_step, num_step[PIX_W-1]};
      num_step = {num_step[PIX_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_step = REM_W'(trial - {1'b0, dvs});
        quo_step = {quo_step[PIX_W-2:0], 1'b1};
      end else begin
        rem_step = trial[REM_W-1:0];
        quo_step = {quo_step[PIX_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        k <= '0;
      end else if (load_out) begin
        k <= is_last ? '0 : k + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        rem    <= numer[NUM_W-1:PIX_W];
        num_lo <= numer[PIX_W-1:0];
        quo    <= '0;
      end
      ST_DIV0, ST_DIV1: begin
        rem    <= rem_step;
        num_lo <= num_step;
        quo    <= quo_step;
      end
      default: begin
        rem    <= rem;
        num_lo <= num_lo;
        quo    <= quo;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      scaled_value <= (head.range == '0) ? '0 : quo;
      last_result  <= is_last;
      overflow     <= head.ovf;
    end
  end

endmodule
`default_nettype wire

// File: rtl/min_max_normalize_top.sv
// Top level of the min-max contrast stretch block.
//
//   channel  | handshake                   | payload
//   sample   | sample_valid / sample_ready | sample_value, last_sample
//   result   | result_valid / result_ready | scaled_value, last_result, overflow
//
// Samples load at one per cycle while sample_ready is high, into one half of the sample RAM.
// In the back end each result goes through RAM read, dividend setup, the division
// states ST_DIV0 and ST_DIV1 of four quotient bits each, and the output register load.
// Two patches can be held at once (one per RAM half); sample_ready drops only
// while both halves hold patches not yet fully drained.
// Reset clears control state; RAM contents are not cleared.
// A stalled result holds the back end; the front keeps loading meanwhile until the queue is full.
`default_nettype none
module min_max_normalize_top #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [mmn_pkg::PIX_W-1:0]   sample_value,
  input  wire logic                        last_sample,
  input  wire logic                        sample_valid,
  output logic                             sample_ready,
  output logic [mmn_pkg::PIX_W-1:0]        scaled_value,
  output logic                             last_result,
  output logic                             overflow,
  output logic                             result_valid,
  input  wire logic                        result_ready
);
  import mmn_pkg::*;

  localparam int IDX_W     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int RAM_DEPTH = 2 << IDX_W;

  queue_stat_t      q_stat;
  patch_desc_t      push_desc;
  patch_desc_t      head;
  logic             push;
  logic             pop;
  logic             wr_en;
  logic [IDX_W:0]   wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic [IDX_W:0]   rd_addr;
  logic [PIX_W-1:0] rd_data;

  mmn_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample_value(sample_value),
    .last_sample (last_sample),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .q_stat      (q_stat),
    .push        (push),
    .desc        (push_desc),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  mmn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  mmn_ram #(
    .WIDTH(PIX_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mmn_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .head        (head),
    .pop         (pop),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .scaled_value(scaled_value),
    .last_result (last_result),
    .overflow    (overflow),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("patch pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("patch popped from empty queue");

  a_ovf_full_count: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && head.ovf) |-> (head.cnt == CNT_W'(MAX_ELEMENTS)))
    else $error("overflow flagged on a patch that did not fill the buffer");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> (head.cnt != '0))
    else $error("queued patch has no stored samples");

endmodule
`default_nettype wire

// File: test/min_max_normalize_top_tb.sv
// Testbench for min_max_normalize_top: directed and random patches checked against a min-max stretch predictor.
`timescale 1ns / 1ps

typedef struct packed {
  logic [mmn_pkg::PIX_W-1:0] scaled;
  logic                      last;
  logic                      ovf;
} stretched_pixel_t;

class stretch_scoreboard #(int DEPTH = 64);
  localparam int IDX_W = $clog2(DEPTH);

  logic [mmn_pkg::PIX_W-1:0] patch_mem [DEPTH];
  logic [mmn_pkg::PIX_W-1:0] run_lo;
  logic [mmn_pkg::PIX_W-1:0] run_hi;
  int unsigned               fill;
  bit                        dropped;
  stretched_pixel_t          stretched_q [$];
  int unsigned               errors;

  function new();
    errors = 0;
    clear_patch();
  endfunction

  function void clear_patch();
    run_lo  = 8'hff;
    run_hi  = 8'h00;
    fill    = 0;
    dropped = 1'b0;
  endfunction

  function int unsigned pending();
    return stretched_q.size();
  endfunction

  function void note_sample(logic [mmn_pkg::PIX_W-1:0] v, logic last);
    int unsigned span;
    int unsigned s;
    stretched_pixel_t px;
    if (fill < DEPTH) begin
      patch_mem[fill[IDX_W-1:0]] = v;
      fill++;
      if (v < run_lo) run_lo = v;
      if (v > run_hi) run_hi = v;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    span = (run_hi >= run_lo) ? 32'(run_hi - run_lo) : 0;
    for (int k = 0; k < fill; k++) begin
      s = 32'(patch_mem[k[IDX_W-1:0]]);
      if (s < run_lo) s = 32'(run_lo);
      if (span == 0) px.scaled = '0;
      else px.scaled = 8'((2 * (s - run_lo) * mmn_pkg::FULL_SCALE + span) / (2 * span));
      px.last = (k == fill - 1);
      px.ovf  = dropped;
      stretched_q.push_back(px);
    end
    clear_patch();
  endfunction

  function void check_result(logic [mmn_pkg::PIX_W-1:0] scaled, logic last, logic ovf);
    stretched_pixel_t px;
    if (stretched_q.size() == 0) begin
      $error("unexpected result: scaled_value=%0d last_result=%0b overflow=%0b",
             scaled, last, ovf);
      errors++;
      return;
    end
    px = stretched_q.pop_front();
    if (scaled !== px.scaled) begin
      $error("scaled_value: expected %0d, actual %0d", px.scaled, scaled);
      errors++;
    end
    if (last !== px.last) begin
      $error("last_result: expected %0b, actual %0b", px.last, last);
      errors++;
    end
    if (ovf !== px.ovf) begin
      $error("overflow: expected %0b, actual %0b", px.ovf, ovf);
      errors++;
    end
  endfunction
endclass

module min_max_normalize_top_tb;
  localparam int DEPTH        = 64;
  localparam int ITEM_TARGET  = 370;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum {FILL_RANDOM, FILL_NARROW, FILL_FLAT, FILL_EXTREME} fill_kind_t;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic [mmn_pkg::PIX_W-1:0] sample_value = '0;
  logic                      last_sample  = 1'b0;
  logic                      sample_valid = 1'b0;
  logic                      sample_ready;
  logic [mmn_pkg::PIX_W-1:0] scaled_value;
  logic                      last_result;
  logic                      overflow;
  logic                      result_valid;
  logic                      result_ready = 1'b0;

  stretch_scoreboard #(DEPTH) sb;
  bit          quiet        = 1'b0;
  int unsigned samples_sent = 0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;

  min_max_normalize_top #(.MAX_ELEMENTS(DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .scaled_value (scaled_value),
    .last_result  (last_result),
    .overflow     (overflow),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(input logic [mmn_pkg::PIX_W-1:0] v, input logic last);
    int unsigned gap;
    sample_value <= v;
    last_sample  <= last;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(v, last);
    samples_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_result(scaled_value, last_result, overflow);
    if (quiet) begin
      result_ready <= 1'b1;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left--;
    end else begin
      result_ready <= 1'b1;
      hold_left = pick_gap();
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("min_max_normalize_top: mismatch");
    $finish;
  end

  initial begin
    int unsigned plen;
    int unsigned r;
    int unsigned base;
    int unsigned wid;
    bit          first_patch;
    fill_kind_t  fill;
    logic [mmn_pkg::PIX_W-1:0] v;

    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-sample patches, flat patch, extremes, half-up rounding, min after max
    send_sample(8'd0, 1'b1);
    send_sample(8'd255, 1'b1);
    send_sample(8'd77, 1'b0);
    send_sample(8'd77, 1'b0);
    send_sample(8'd77, 1'b1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd1, 1'b0);
    send_sample(8'd254, 1'b1);
    send_sample(8'd10, 1'b0);
    send_sample(8'd11, 1'b0);
    send_sample(8'd12, 1'b1);
    send_sample(8'd200, 1'b0);
    send_sample(8'd100, 1'b1);
    send_sample(8'h55, 1'b0);
    send_sample(8'haa, 1'b1);

    // hold off until the back end is empty
    wait_drained();

    first_patch = 1'b1;
    while (samples_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (first_patch) begin
        plen = $urandom_range(DEPTH + 1, DEPTH + 6);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) plen = $urandom_range(1, 16);
        else if (r < 90) plen = $urandom_range(17, DEPTH - 1);
        else plen = $urandom_range(DEPTH - 4, DEPTH + 8);
      end
      first_patch = 1'b0;
      fill = fill_kind_t'($urandom_range(0, 3));
      base = $urandom_range(0, 255);
      wid  = $urandom_range(0, 7);
      for (int i = 0; i < plen; i++) begin
        case (fill)
          FILL_RANDOM:  v = 8'($urandom);
          FILL_NARROW:  v = 8'(base + $urandom_range(0, wid));
          FILL_FLAT:    v = 8'(base);
          default:      v = $urandom_range(0, 1) ? 8'hff : 8'h00;
        endcase
        send_sample(v, i == plen - 1);
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("min_max_normalize_top: match");
    else
      $display("min_max_normalize_top: mismatch");
    $finish;
  end
endmodule
